FILE: hw/rtl/hctt_pkg.sv
// hctt_pkg: shared constants, codes and types of the hashed trie child table
// no dependencies

package hctt_pkg;

    localparam int SLOTS_DEF            = 4096;
    localparam int MAX_ALPHABET_DEF     = 256;
    localparam int DSP1_WIDTH_DEF       = 4;
    localparam int OVERFLOW_ENTRIES_DEF = 64;

    localparam int N_W    = 13;
    localparam int ALP_W  = 9;
    localparam int PRIME_W = 21;
    localparam int MULT_W = 63;
    localparam int ROOT_W = 12;
    localparam int CFG_W  = 63;
    localparam int CFG_IDX_W = 3;
    localparam int ACT_W  = 2;
    localparam int NODE_W = 12;
    localparam int SYM_W  = 8;
    localparam int STAT_W = 3;
    localparam int PROD_W = 64;
    localparam int KEY_W  = 21;
    localparam int NBITS_W = 7;

    localparam logic [CFG_IDX_W-1:0] CFG_SLOTS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALP    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PRIME  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MULT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ROOT   = 3'd4;

    localparam logic [N_W-1:0]     SLOTS_RST = 13'd4096;
    localparam logic [ALP_W-1:0]   ALP_RST   = 9'd256;
    localparam logic [PRIME_W-1:0] PRIME_RST = 21'd2097143;
    localparam logic [MULT_W-1:0]  MULT_RST  = 63'd8796130771106;
    localparam logic [ROOT_W-1:0]  ROOT_RST  = 12'd2048;

    localparam logic [ACT_W-1:0] ACT_FIND = 2'd0;

    localparam logic [STAT_W-1:0] ST_FOUND    = 3'd0;
    localparam logic [STAT_W-1:0] ST_INSERTED = 3'd1;
    localparam logic [STAT_W-1:0] ST_ABSENT   = 3'd2;
    localparam logic [STAT_W-1:0] ST_BAD_SYM  = 3'd3;
    localparam logic [STAT_W-1:0] ST_BAD_QUO  = 3'd4;
    localparam logic [STAT_W-1:0] ST_FULL     = 3'd5;
    localparam logic [STAT_W-1:0] ST_OV_FULL  = 3'd6;

    localparam logic [N_W-1:0] COUNT_MAX = 13'd8191;

    typedef struct packed {
        logic [PROD_W-1:0]  dividend;
        logic [PRIME_W-1:0] divisor;
        logic [NBITS_W-1:0] nbits;
    } div_req_t;

endpackage

FILE: hw/rtl/hctt_ram.sv
// hctt_ram: generic single write port, single read port ram, registered read
// no dependencies

module hctt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                 clk,
    input  logic                                 we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                     wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: hw/rtl/hctt_div.sv
// hctt_div: shared restoring divider, one quotient bit per cycle
// depends on hctt_pkg

module hctt_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        go,
    input  hctt_pkg::div_req_t          req,
    output logic                        done,
    output logic [hctt_pkg::PROD_W-1:0] quotient,
    output logic [hctt_pkg::PRIME_W-1:0] remainder
);

    logic                          run_reg, run_next;
    logic                          done_reg, done_next;
    logic [hctt_pkg::NBITS_W-1:0]  cnt_reg, cnt_next;
    logic [hctt_pkg::PROD_W-1:0]   q_reg, q_next;
    logic [hctt_pkg::PRIME_W-1:0]  r_reg, r_next;
    logic [hctt_pkg::PRIME_W-1:0]  d_reg, d_next;
    logic [hctt_pkg::PRIME_W:0]    sh;
    logic [hctt_pkg::PRIME_W:0]    diff;
    logic                          ge;

    always_comb
    begin
        sh   = {r_reg, q_reg[hctt_pkg::PROD_W-1]};
        ge   = sh >= {1'b0, d_reg};
        diff = sh - {1'b0, d_reg};
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        if (go)
        begin
            run_next = 1'b1;
            cnt_next = req.nbits;
            q_next   = req.dividend;
            r_next   = '0;
            d_next   = req.divisor;
        end
        else if (run_reg)
        begin
            q_next   = {q_reg[hctt_pkg::PROD_W-2:0], ge};
            r_next   = ge ? diff[hctt_pkg::PRIME_W-1:0] : sh[hctt_pkg::PRIME_W-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == hctt_pkg::NBITS_W'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign done      = done_reg;
    assign quotient  = q_reg;
    assign remainder = r_reg;

endmodule

FILE: hw/rtl/hashed_trie_child_table.sv
// hashed_trie_child_table: find or add a child in a compact hash trie
// depends on hctt_pkg, hctt_ram, hctt_div
// hashing runs on the shared divider and serial multiplier, then slots are probed, skipping
// the root slot and scanning overflow entries, then done strobes for one cycle; one
// transaction at a time, busy high throughout
// reset: slot table clearing pass over all SLOTS entries with busy high, config to defaults

module hashed_trie_child_table #(
    parameter int SLOTS            = hctt_pkg::SLOTS_DEF,
    parameter int MAX_ALPHABET     = hctt_pkg::MAX_ALPHABET_DEF,
    parameter int DSP1_WIDTH       = hctt_pkg::DSP1_WIDTH_DEF,
    parameter int OVERFLOW_ENTRIES = hctt_pkg::OVERFLOW_ENTRIES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [hctt_pkg::ACT_W-1:0]      action,
    input  logic [hctt_pkg::NODE_W-1:0]     node_id,
    input  logic [hctt_pkg::SYM_W-1:0]      symbol,
    output logic                            done,
    output logic [hctt_pkg::STAT_W-1:0]     status,
    output logic [hctt_pkg::NODE_W-1:0]     child_node,
    output logic [hctt_pkg::N_W-1:0]        node_count,
    input  logic                            cfg_write,
    input  logic [hctt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [hctt_pkg::CFG_W-1:0]      cfg_data
);

    localparam int POS_W  = $clog2(SLOTS);
    localparam int QUO_W  = $clog2(MAX_ALPHABET + 2);
    localparam int SLOT_W = 1 + QUO_W + DSP1_WIDTH;
    localparam int OV_W   = 2 * POS_W;
    localparam int OV_AW  = OVERFLOW_ENTRIES > 1 ? $clog2(OVERFLOW_ENTRIES) : 1;
    localparam int OVC_W  = $clog2(OVERFLOW_ENTRIES + 1);
    localparam logic [DSP1_WIDTH-1:0] DSP1_MAX = {DSP1_WIDTH{1'b1}};
    localparam int SH = hctt_pkg::PROD_W - hctt_pkg::KEY_W;

    localparam logic [3:0] S_CLEAR    = 4'd0;
    localparam logic [3:0] S_IDLE     = 4'd1;
    localparam logic [3:0] S_PREP     = 4'd2;
    localparam logic [3:0] S_DIV_C    = 4'd3;
    localparam logic [3:0] S_MUL      = 4'd4;
    localparam logic [3:0] S_DIV_P    = 4'd5;
    localparam logic [3:0] S_DIV_N    = 4'd6;
    localparam logic [3:0] S_PROBE    = 4'd7;
    localparam logic [3:0] S_CHECK    = 4'd8;
    localparam logic [3:0] S_OV_READ  = 4'd9;
    localparam logic [3:0] S_OV_CHECK = 4'd10;

    // configuration
    logic [hctt_pkg::N_W-1:0]     cfg_n_reg;
    logic [hctt_pkg::ALP_W-1:0]   cfg_alp_reg;
    logic [hctt_pkg::PRIME_W-1:0] cfg_p_reg;
    logic [hctt_pkg::MULT_W-1:0]  cfg_m_reg;
    logic [hctt_pkg::ROOT_W-1:0]  cfg_root_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_n_reg    <= hctt_pkg::SLOTS_RST;
            cfg_alp_reg  <= hctt_pkg::ALP_RST;
            cfg_p_reg    <= hctt_pkg::PRIME_RST;
            cfg_m_reg    <= hctt_pkg::MULT_RST;
            cfg_root_reg <= hctt_pkg::ROOT_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                hctt_pkg::CFG_SLOTS: cfg_n_reg    <= cfg_data[hctt_pkg::N_W-1:0];
                hctt_pkg::CFG_ALP:   cfg_alp_reg  <= cfg_data[hctt_pkg::ALP_W-1:0];
                hctt_pkg::CFG_PRIME: cfg_p_reg    <= cfg_data[hctt_pkg::PRIME_W-1:0];
                hctt_pkg::CFG_MULT:  cfg_m_reg    <= cfg_data[hctt_pkg::MULT_W-1:0];
                hctt_pkg::CFG_ROOT:  cfg_root_reg <= cfg_data[hctt_pkg::ROOT_W-1:0];
                default: ;
            endcase
        end
    end

    // sequencer state
    logic [3:0]                   state_reg, state_next;
    logic [hctt_pkg::ACT_W-1:0]   act_reg, act_next;
    logic [hctt_pkg::NODE_W-1:0]  node_reg, node_next;
    logic [hctt_pkg::SYM_W-1:0]   sym_reg, sym_next;
    logic [hctt_pkg::N_W-1:0]     n_reg, n_next;
    logic [hctt_pkg::ALP_W-1:0]   alp_reg, alp_next;
    logic [hctt_pkg::PRIME_W-1:0] p_reg, p_next;
    logic [hctt_pkg::KEY_W-1:0]   quo_reg, quo_next;
    logic [hctt_pkg::KEY_W-1:0]   x_reg, x_next;
    logic [hctt_pkg::PROD_W-1:0]  acc_reg, acc_next;
    logic [4:0]                   mcnt_reg, mcnt_next;
    logic [POS_W-1:0]             pos_reg, pos_next;
    logic [hctt_pkg::N_W-1:0]     cnt_reg, cnt_next;
    logic [POS_W-1:0]             clr_reg, clr_next;
    logic [OV_AW-1:0]             ov_idx_reg, ov_idx_next;
    logic [OVC_W-1:0]             ov_count_reg, ov_count_next;
    logic [hctt_pkg::N_W-1:0]     count_reg, count_next;
    logic                         done_reg, done_next;
    logic [hctt_pkg::STAT_W-1:0]  status_reg, status_next;
    logic [hctt_pkg::NODE_W-1:0]  child_reg, child_next;

    // shared divider
    logic                          div_go;
    hctt_pkg::div_req_t            div_req;
    logic                          div_done;
    logic [hctt_pkg::PROD_W-1:0]   div_q;
    logic [hctt_pkg::PRIME_W-1:0]  div_r;

    hctt_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .go        (div_go),
        .req       (div_req),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    // memories
    logic                          slot_we;
    logic [POS_W-1:0]              slot_waddr;
    logic [SLOT_W-1:0]             slot_wdata;
    logic [SLOT_W-1:0]             slot_rdata;
    logic                          ov_we;
    logic [OV_AW-1:0]              ov_waddr;
    logic [OV_W-1:0]               ov_wdata;
    logic [OV_W-1:0]               ov_rdata;

    hctt_ram #(.WIDTH(SLOT_W), .DEPTH(SLOTS)) u_slot_ram (
        .clk   (clk),
        .we    (slot_we),
        .waddr (slot_waddr),
        .wdata (slot_wdata),
        .raddr (pos_reg),
        .rdata (slot_rdata)
    );

    hctt_ram #(.WIDTH(OV_W), .DEPTH(OVERFLOW_ENTRIES)) u_ov_ram (
        .clk   (clk),
        .we    (ov_we),
        .waddr (ov_waddr),
        .wdata (ov_wdata),
        .raddr (ov_idx_reg),
        .rdata (ov_rdata)
    );

    logic                   e_valid;
    logic [QUO_W-1:0]       e_quo;
    logic [DSP1_WIDTH-1:0]  e_dsp1;
    logic [POS_W-1:0]       o_pos;
    logic [POS_W-1:0]       o_dsp;
    logic                   is_add;
    logic                   is_tail;
    logic [hctt_pkg::KEY_W-1:0] key_c;
    logic [POS_W-1:0]       pos_inc;
    logic [31:0]            pos_ext;
    logic [hctt_pkg::N_W-1:0] cnt_inc;

    always_comb
    begin
        e_valid = slot_rdata[SLOT_W-1];
        e_quo   = slot_rdata[SLOT_W-2 -: QUO_W];
        e_dsp1  = slot_rdata[DSP1_WIDTH-1:0];
        o_pos   = ov_rdata[OV_W-1 -: POS_W];
        o_dsp   = ov_rdata[POS_W-1:0];
        is_add  = act_reg != hctt_pkg::ACT_FIND;
        is_tail = act_reg[1];
        key_c   = hctt_pkg::KEY_W'(sym_reg) * hctt_pkg::KEY_W'(n_reg)
                + hctt_pkg::KEY_W'(node_reg);
        pos_inc = ((32'(pos_reg) + 32'd1) >= 32'(n_reg)) ? '0 : pos_reg + 1'b1;
        pos_ext = 32'(pos_reg);
        cnt_inc = cnt_reg + 1'b1;
    end

    always_comb
    begin
        state_next    = state_reg;
        act_next      = act_reg;
        node_next     = node_reg;
        sym_next      = sym_reg;
        n_next        = n_reg;
        alp_next      = alp_reg;
        p_next        = p_reg;
        quo_next      = quo_reg;
        x_next        = x_reg;
        acc_next      = acc_reg;
        mcnt_next     = mcnt_reg;
        pos_next      = pos_reg;
        cnt_next      = cnt_reg;
        clr_next      = clr_reg;
        ov_idx_next   = ov_idx_reg;
        ov_count_next = ov_count_reg;
        count_next    = count_reg;
        done_next     = 1'b0;
        status_next   = status_reg;
        child_next    = child_reg;
        div_go        = 1'b0;
        div_req       = '0;
        slot_we       = 1'b0;
        slot_waddr    = pos_reg;
        slot_wdata    = '0;
        ov_we         = 1'b0;
        ov_waddr      = ov_count_reg[OV_AW-1:0];
        ov_wdata      = {pos_reg, cnt_reg[POS_W-1:0]};

        case (state_reg)
            S_CLEAR:
            begin
                slot_we    = 1'b1;
                slot_waddr = clr_reg;
                clr_next   = clr_reg + 1'b1;
                if (32'(clr_reg) == SLOTS - 1)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    act_next  = action;
                    node_next = node_id;
                    sym_next  = symbol;
                    if (cfg_n_reg == '0)
                    begin
                        n_next = hctt_pkg::N_W'(1);
                    end
                    else if (32'(cfg_n_reg) > SLOTS)
                    begin
                        n_next = hctt_pkg::N_W'(SLOTS);
                    end
                    else
                    begin
                        n_next = cfg_n_reg;
                    end
                    alp_next = (32'(cfg_alp_reg) > MAX_ALPHABET)
                             ? hctt_pkg::ALP_W'(MAX_ALPHABET) : cfg_alp_reg;
                    p_next   = (cfg_p_reg == '0) ? hctt_pkg::PRIME_W'(1) : cfg_p_reg;
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                if (hctt_pkg::ALP_W'(sym_reg) >= alp_reg)
                begin
                    status_next = hctt_pkg::ST_BAD_SYM;
                    child_next  = node_reg;
                    done_next   = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    div_go           = 1'b1;
                    div_req.dividend = {key_c, {SH{1'b0}}};
                    div_req.divisor  = p_reg;
                    div_req.nbits    = hctt_pkg::NBITS_W'(hctt_pkg::KEY_W);
                    state_next       = S_DIV_C;
                end
            end
            S_DIV_C:
            begin
                if (div_done)
                begin
                    x_next     = div_r;
                    acc_next   = '0;
                    mcnt_next  = '0;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                // shift-add, most significant multiplier bit first, mod 2^64
                acc_next  = {acc_reg[hctt_pkg::PROD_W-2:0], 1'b0}
                          + (x_reg[hctt_pkg::KEY_W-1] ? {1'b0, cfg_m_reg} : '0);
                x_next    = {x_reg[hctt_pkg::KEY_W-2:0], 1'b0};
                mcnt_next = mcnt_reg + 1'b1;
                if (mcnt_reg == 5'(hctt_pkg::KEY_W - 1))
                begin
                    state_next = S_DIV_P;
                end
            end
            S_DIV_P:
            begin
                if (mcnt_reg != '0)
                begin
                    mcnt_next        = '0;
                    div_go           = 1'b1;
                    div_req.dividend = acc_reg;
                    div_req.divisor  = p_reg;
                    div_req.nbits    = hctt_pkg::NBITS_W'(hctt_pkg::PROD_W);
                end
                else if (div_done)
                begin
                    div_go           = 1'b1;
                    div_req.dividend = {div_r, {SH{1'b0}}};
                    div_req.divisor  = hctt_pkg::PRIME_W'(n_reg);
                    div_req.nbits    = hctt_pkg::NBITS_W'(hctt_pkg::KEY_W);
                    state_next       = S_DIV_N;
                end
            end
            S_DIV_N:
            begin
                if (div_done)
                begin
                    quo_next = div_q[hctt_pkg::KEY_W-1:0];
                    pos_next = div_r[POS_W-1:0];
                    cnt_next = '0;
                    if (div_q[hctt_pkg::KEY_W-1:0] >= hctt_pkg::KEY_W'(alp_reg) + 2'd2)
                    begin
                        status_next = hctt_pkg::ST_BAD_QUO;
                        child_next  = node_reg;
                        done_next   = 1'b1;
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_PROBE;
                    end
                end
            end
            S_PROBE:
            begin
                if (cnt_reg == n_reg)
                begin
                    status_next = hctt_pkg::ST_FULL;
                    child_next  = node_reg;
                    done_next   = 1'b1;
                    state_next  = S_IDLE;
                end
                else if (pos_ext == 32'(cfg_root_reg))
                begin
                    cnt_next = cnt_inc;
                    pos_next = pos_inc;
                end
                else
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (!e_valid)
                begin
                    if (!is_add)
                    begin
                        status_next = hctt_pkg::ST_ABSENT;
                        child_next  = node_reg;
                        done_next   = 1'b1;
                        state_next  = S_IDLE;
                    end
                    else if (32'(cnt_reg) >= 32'(DSP1_MAX)
                             && 32'(ov_count_reg) == OVERFLOW_ENTRIES)
                    begin
                        status_next = hctt_pkg::ST_OV_FULL;
                        child_next  = node_reg;
                        done_next   = 1'b1;
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        slot_we = 1'b1;
                        if (32'(cnt_reg) >= 32'(DSP1_MAX))
                        begin
                            ov_we         = 1'b1;
                            ov_count_next = ov_count_reg + 1'b1;
                            slot_wdata    = {1'b1, quo_reg[QUO_W-1:0], DSP1_MAX};
                        end
                        else
                        begin
                            slot_wdata = {1'b1, quo_reg[QUO_W-1:0],
                                          cnt_reg[DSP1_WIDTH-1:0]};
                        end
                        if (count_reg != hctt_pkg::COUNT_MAX)
                        begin
                            count_next = count_reg + 1'b1;
                        end
                        status_next = hctt_pkg::ST_INSERTED;
                        child_next  = pos_ext[hctt_pkg::NODE_W-1:0];
                        done_next   = 1'b1;
                        state_next  = S_IDLE;
                    end
                end
                else if (is_tail || e_quo != quo_reg[QUO_W-1:0])
                begin
                    cnt_next   = cnt_inc;
                    pos_next   = pos_inc;
                    state_next = S_PROBE;
                end
                else if (e_dsp1 != DSP1_MAX)
                begin
                    if (32'(e_dsp1) == 32'(cnt_reg))
                    begin
                        status_next = hctt_pkg::ST_FOUND;
                        child_next  = pos_ext[hctt_pkg::NODE_W-1:0];
                        done_next   = 1'b1;
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        cnt_next   = cnt_inc;
                        pos_next   = pos_inc;
                        state_next = S_PROBE;
                    end
                end
                else if (ov_count_reg == '0)
                begin
                    cnt_next   = cnt_inc;
                    pos_next   = pos_inc;
                    state_next = S_PROBE;
                end
                else
                begin
                    ov_idx_next = '0;
                    state_next  = S_OV_READ;
                end
            end
            S_OV_READ:
            begin
                state_next = S_OV_CHECK;
            end
            S_OV_CHECK:
            begin
                if (o_pos == pos_reg)
                begin
                    if (32'(o_dsp) == 32'(cnt_reg))
                    begin
                        status_next = hctt_pkg::ST_FOUND;
                        child_next  = pos_ext[hctt_pkg::NODE_W-1:0];
                        done_next   = 1'b1;
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        cnt_next   = cnt_inc;
                        pos_next   = pos_inc;
                        state_next = S_PROBE;
                    end
                end
                else if (32'(ov_idx_reg) + 32'd1 == 32'(ov_count_reg))
                begin
                    cnt_next   = cnt_inc;
                    pos_next   = pos_inc;
                    state_next = S_PROBE;
                end
                else
                begin
                    ov_idx_next = ov_idx_reg + 1'b1;
                    state_next  = S_OV_READ;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            clr_reg      <= '0;
            ov_count_reg <= '0;
            count_reg    <= hctt_pkg::N_W'(1);
            done_reg     <= 1'b0;
            mcnt_reg     <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_reg      <= clr_next;
            ov_count_reg <= ov_count_next;
            count_reg    <= count_next;
            done_reg     <= done_next;
            mcnt_reg     <= mcnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg    <= act_next;
        node_reg   <= node_next;
        sym_reg    <= sym_next;
        n_reg      <= n_next;
        alp_reg    <= alp_next;
        p_reg      <= p_next;
        quo_reg    <= quo_next;
        x_reg      <= x_next;
        acc_reg    <= acc_next;
        pos_reg    <= pos_next;
        cnt_reg    <= cnt_next;
        ov_idx_reg <= ov_idx_next;
        status_reg <= status_next;
        child_reg  <= child_next;
    end

    assign busy       = state_reg != S_IDLE;
    assign done       = done_reg;
    assign status     = status_reg;
    assign child_node = child_reg;
    assign node_count = count_reg;

endmodule
